>>> rtl/afd_pkg.sv
// ----------------------------------------------------------------------------
// afd_pkg
// Shared types and constants of the API frame deframer.
// ----------------------------------------------------------------------------
package afd_pkg;

    localparam logic [15:0] TIMEOUT_RESET   = 16'd30;
    localparam logic [15:0] MAX_FRAME_RESET = 16'd100;
    localparam logic [16:0] HDR_AND_SUM     = 17'd4;
    localparam logic [15:0] LEN_DONE_COUNT  = 16'd3;
    localparam logic [7:0]  SUM_BASE        = 8'hFF;

    localparam logic [0:0]  REG_TIMEOUT     = 1'd0;
    localparam logic [0:0]  REG_MAX_FRAME   = 1'd1;

    localparam logic [1:0]  ST_OK           = 2'd0;
    localparam logic [1:0]  ST_BAD_SUM      = 2'd1;
    localparam logic [1:0]  ST_TOO_LONG     = 2'd2;
    localparam logic [1:0]  ST_TIMEOUT      = 2'd3;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [15:0] max_frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_frame_type;
        logic        end_of_frame;
        logic [1:0]  status;
        logic [15:0] frame_data_length;
    } result_t;

endpackage

>>> rtl/afd_cfg.sv
// ----------------------------------------------------------------------------
// afd_cfg
// Configuration registers: timeout and maximum frame size.
// ----------------------------------------------------------------------------
module afd_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output afd_pkg::cfg_t       cfg
);

    afd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= afd_pkg::TIMEOUT_RESET;
            cfg_reg.max_frame_bytes <= afd_pkg::MAX_FRAME_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                afd_pkg::REG_TIMEOUT:   cfg_reg.timeout_ticks   <= cfg_data;
                afd_pkg::REG_MAX_FRAME: cfg_reg.max_frame_bytes <= cfg_data;
                default:                cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/afd_core.sv
// ----------------------------------------------------------------------------
// afd_core
// Frame parser state: header count, length, checksum sum and idle ticks.
// ----------------------------------------------------------------------------
module afd_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  afd_pkg::cfg_t       cfg,
    input  logic                beat,
    input  logic                req_type,
    input  logic [7:0]          in_byte,
    output logic                res_valid,
    output afd_pkg::result_t    res
);

    logic [15:0] byte_count_reg,  byte_count_next;
    logic [7:0]  length_high_reg, length_high_next;
    logic [16:0] frame_total_reg, frame_total_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [15:0] idle_ticks_reg,  idle_ticks_next;

    logic [15:0] ticks_inc;
    logic [16:0] new_total;
    logic [15:0] cur_len;
    logic [16:0] count_inc;
    logic [7:0]  expect_sum;

    always_comb
    begin
        ticks_inc        = idle_ticks_reg + 16'd1;
        new_total        = {1'b0, length_high_reg, in_byte} + afd_pkg::HDR_AND_SUM;
        cur_len          = 16'(frame_total_reg - afd_pkg::HDR_AND_SUM);
        count_inc        = {1'b0, byte_count_reg} + 17'd1;
        expect_sum       = afd_pkg::SUM_BASE - running_sum_reg;

        byte_count_next  = byte_count_reg;
        length_high_next = length_high_reg;
        frame_total_next = frame_total_reg;
        running_sum_next = running_sum_reg;
        idle_ticks_next  = idle_ticks_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (req_type)
        begin
            if (byte_count_reg != 16'd0)
            begin
                if (ticks_inc >= cfg.timeout_ticks)
                begin
                    res_valid        = 1'b1;
                    res.end_of_frame = 1'b1;
                    res.status       = afd_pkg::ST_TIMEOUT;
                    res.frame_data_length =
                        (byte_count_reg >= afd_pkg::LEN_DONE_COUNT) ? cur_len : 16'd0;
                    byte_count_next  = '0;
                    length_high_next = '0;
                    frame_total_next = '0;
                    running_sum_next = '0;
                    idle_ticks_next  = '0;
                end
                else
                begin
                    idle_ticks_next = ticks_inc;
                end
            end
        end
        else
        begin
            idle_ticks_next = '0;
            priority if (byte_count_reg == 16'd0)
            begin
                byte_count_next = 16'd1;
            end
            else if (byte_count_reg == 16'd1)
            begin
                length_high_next = in_byte;
                byte_count_next  = 16'd2;
            end
            else if (byte_count_reg == 16'd2)
            begin
                if (new_total > {1'b0, cfg.max_frame_bytes})
                begin
                    res_valid             = 1'b1;
                    res.end_of_frame      = 1'b1;
                    res.status            = afd_pkg::ST_TOO_LONG;
                    res.frame_data_length = {length_high_reg, in_byte};
                    byte_count_next       = '0;
                    length_high_next      = '0;
                    frame_total_next      = '0;
                    running_sum_next      = '0;
                end
                else
                begin
                    frame_total_next = new_total;
                    running_sum_next = '0;
                    byte_count_next  = afd_pkg::LEN_DONE_COUNT;
                end
            end
            else if (count_inc >= frame_total_reg)
            begin
                res_valid             = 1'b1;
                res.data_byte         = in_byte;
                res.end_of_frame      = 1'b1;
                res.status            = (expect_sum == in_byte) ? afd_pkg::ST_OK
                                                                : afd_pkg::ST_BAD_SUM;
                res.frame_data_length = cur_len;
                byte_count_next       = '0;
                length_high_next      = '0;
                frame_total_next      = '0;
                running_sum_next      = '0;
            end
            else
            begin
                res_valid         = 1'b1;
                res.data_byte     = in_byte;
                res.is_frame_type = (byte_count_reg == afd_pkg::LEN_DONE_COUNT);
                res.status        = afd_pkg::ST_OK;
                running_sum_next  = running_sum_reg + in_byte;
                byte_count_next   = count_inc[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg  <= '0;
            length_high_reg <= '0;
            frame_total_reg <= '0;
            running_sum_reg <= '0;
            idle_ticks_reg  <= '0;
        end
        else if (beat)
        begin
            byte_count_reg  <= byte_count_next;
            length_high_reg <= length_high_next;
            frame_total_reg <= frame_total_next;
            running_sum_reg <= running_sum_next;
            idle_ticks_reg  <= idle_ticks_next;
        end
    end

    a_idle_no_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg == 16'd0) |-> (idle_ticks_reg == 16'd0))
        else $error("idle ticks counted outside a frame");

    a_total_known: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_count_reg >= afd_pkg::LEN_DONE_COUNT) |->
        (frame_total_reg >= afd_pkg::HDR_AND_SUM) && ({1'b0, byte_count_reg} < frame_total_reg))
        else $error("byte count ran past frame total");

    a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && res_valid && res.end_of_frame) |=> (byte_count_reg == 16'd0))
        else $error("frame closed but parser not idle");

    a_type_first: assert property (@(posedge clk) disable iff (!rst_n)
        (beat && res_valid && res.is_frame_type) |=> (byte_count_reg == 16'd4))
        else $error("frame type flagged off the first data byte");

endmodule

>>> rtl/afd_out.sv
// ----------------------------------------------------------------------------
// afd_out
// Result register with valid/ready handshake toward the consumer.
// ----------------------------------------------------------------------------
module afd_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  logic                res_valid,
    input  afd_pkg::result_t    res,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                can_load,
    output afd_pkg::result_t    out_res
);

    logic             valid_reg, valid_next;
    afd_pkg::result_t res_reg;

    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res_valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

>>> rtl/api_frame_deframer.sv
// ----------------------------------------------------------------------------
// api_frame_deframer
// Radio-module API frame receiver with length, checksum and timeout checks.
// ----------------------------------------------------------------------------
// One input beat is taken every clock cycle unless stalled, which happens
// only while the single output register holds a result the consumer has
// not yet taken. Each byte or tick updates the parser state when accepted,
// and any result is written into that register at the same time. The start
// byte, first length byte and most ticks give none; frame-data bytes give
// one each, and a frame closes with one end beat carrying status and length.
module api_frame_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic        is_frame_type,
    output logic        end_of_frame,
    output logic [1:0]  status,
    output logic [15:0] frame_data_length
);

    afd_pkg::cfg_t    cfg;
    afd_pkg::result_t res;
    afd_pkg::result_t out_res;
    logic             res_valid;
    logic             can_load;
    logic             beat;

    assign in_ready = can_load;
    assign beat     = in_valid && can_load;

    afd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    afd_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .beat      (beat),
        .req_type  (req_type),
        .in_byte   (in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    afd_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (beat),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .out_res   (out_res)
    );

    assign data_byte         = out_res.data_byte;
    assign is_frame_type     = out_res.is_frame_type;
    assign end_of_frame      = out_res.end_of_frame;
    assign status            = out_res.status;
    assign frame_data_length = out_res.frame_data_length;

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the API frame deframer. A scoreboard class tracks
// frame parsing beat by beat, queues the results each accepted byte or tick
// should produce, and compares every output beat field by field. Directed
// frames exercise the header, checksum, length and timeout paths first.
// Random well-formed frames, broken frames and noise follow under a range of
// register settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TARGET_BEATS   = 1500;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AT_RESULT = 300;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [7:0]  in_byte;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  data_byte;
    logic        is_frame_type;
    logic        end_of_frame;
    logic [1:0]  status;
    logic [15:0] frame_data_length;

    class deframe_model;
        logic [15:0]      timeout_ticks;
        logic [15:0]      max_frame_bytes;
        logic [15:0]      bytes_seen;
        logic [7:0]       len_hi;
        logic [16:0]      total_bytes;
        logic [7:0]       data_sum;
        logic [15:0]      quiet_ticks;
        afd_pkg::result_t pending_results[$];
        int               mismatches;
        int               results_seen;
        int               closed[4];

        function new();
            timeout_ticks   = afd_pkg::TIMEOUT_RESET;
            max_frame_bytes = afd_pkg::MAX_FRAME_RESET;
            mismatches      = 0;
            results_seen    = 0;
            foreach (closed[i])
                closed[i] = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            bytes_seen  = '0;
            len_hi      = '0;
            total_bytes = '0;
            data_sum    = '0;
            quiet_ticks = '0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [15:0] value);
            if (idx == afd_pkg::REG_TIMEOUT)
                timeout_ticks = value;
            else if (idx == afd_pkg::REG_MAX_FRAME)
                max_frame_bytes = value;
        endfunction

        function void queue_result(logic [7:0] d, logic ftype, logic eof,
                                   logic [1:0] st, logic [15:0] len);
            afd_pkg::result_t r;
            r.data_byte         = d;
            r.is_frame_type     = ftype;
            r.end_of_frame      = eof;
            r.status            = st;
            r.frame_data_length = len;
            pending_results.push_back(r);
        endfunction

        // returns 0 for a tick that arrives while no frame is open
        function bit take_beat(logic tick, logic [7:0] b);
            logic [16:0] len17;
            logic [15:0] len;
            logic [7:0]  want_sum;
            len17 = total_bytes - afd_pkg::HDR_AND_SUM;
            len   = len17[15:0];
            if (tick)
            begin
                if (bytes_seen == 16'd0)
                    return 1'b0;
                quiet_ticks = quiet_ticks + 16'd1;
                if (quiet_ticks >= timeout_ticks)
                begin
                    queue_result(8'd0, 1'b0, 1'b1, afd_pkg::ST_TIMEOUT,
                                 (bytes_seen >= afd_pkg::LEN_DONE_COUNT) ? len : 16'd0);
                    clear_frame();
                end
                return 1'b1;
            end
            quiet_ticks = '0;
            if (bytes_seen == 16'd0)
                bytes_seen = 16'd1;
            else if (bytes_seen == 16'd1)
            begin
                len_hi     = b;
                bytes_seen = 16'd2;
            end
            else if (bytes_seen == 16'd2)
            begin
                total_bytes = {1'b0, len_hi, b} + afd_pkg::HDR_AND_SUM;
                if (total_bytes > {1'b0, max_frame_bytes})
                begin
                    queue_result(8'd0, 1'b0, 1'b1, afd_pkg::ST_TOO_LONG, {len_hi, b});
                    clear_frame();
                end
                else
                begin
                    data_sum   = '0;
                    bytes_seen = afd_pkg::LEN_DONE_COUNT;
                end
            end
            else if ({1'b0, bytes_seen} + 17'd1 >= total_bytes)
            begin
                want_sum = afd_pkg::SUM_BASE - data_sum;
                queue_result(b, 1'b0, 1'b1,
                             (want_sum == b) ? afd_pkg::ST_OK : afd_pkg::ST_BAD_SUM, len);
                clear_frame();
            end
            else
            begin
                queue_result(b, bytes_seen == afd_pkg::LEN_DONE_COUNT, 1'b0,
                             afd_pkg::ST_OK, 16'd0);
                data_sum   = data_sum + b;
                bytes_seen = bytes_seen + 16'd1;
            end
            return 1'b1;
        endfunction

        function void cmp(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                         $time, field, want, got);
            end
        endfunction

        function void check_result(afd_pkg::result_t got);
            afd_pkg::result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t ns: unexpected beat, expected none, actual data %0h status %0d",
                         $time, got.data_byte, got.status);
                return;
            end
            want = pending_results.pop_front();
            cmp("data_byte", 16'(want.data_byte), 16'(got.data_byte));
            cmp("is_frame_type", 16'(want.is_frame_type), 16'(got.is_frame_type));
            cmp("end_of_frame", 16'(want.end_of_frame), 16'(got.end_of_frame));
            cmp("status", 16'(want.status), 16'(got.status));
            cmp("frame_data_length", want.frame_data_length, got.frame_data_length);
            if (want.end_of_frame)
                closed[want.status]++;
        endfunction
    endclass

    deframe_model model;
    int           beats_sent;
    int           phases;
    bit           tx_burst;

    api_frame_deframer dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .in_byte           (in_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .data_byte         (data_byte),
        .is_frame_type     (is_frame_type),
        .end_of_frame      (end_of_frame),
        .status            (status),
        .frame_data_length (frame_data_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_beat(logic rt, logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        repeat (gap)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid = 1'b1;
        req_type = rt;
        in_byte  = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (model.take_beat(rt, b))
            beats_sent++;
    endtask

    task automatic send_ticks(int n);
        logic [7:0] junk;
        repeat (n)
        begin
            junk = 8'($urandom_range(0, 255));
            send_beat(1'b1, junk);
        end
    endtask

    // drop valid and wait until every queued result has come out
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (model.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        model.write_reg(idx, value);
    endtask

    task automatic set_regs(logic [15:0] tmo, logic [15:0] max_bytes);
        settle();
        write_reg(afd_pkg::REG_TIMEOUT, tmo);
        write_reg(afd_pkg::REG_MAX_FRAME, max_bytes);
        phases++;
    endtask

    // cut: stop partway and tick the open frame out when the timeout is short
    task automatic send_frame(int len, bit good_sum, bit cut);
        logic [7:0] frame_q[$];
        logic [7:0] b;
        logic [7:0] sum;
        logic [15:0] flen;
        int n;
        bit spatter;
        flen = 16'(len);
        sum  = '0;
        b    = 8'($urandom_range(0, 255));
        frame_q.push_back(b);
        frame_q.push_back(flen[15:8]);
        frame_q.push_back(flen[7:0]);
        if (len + 4 <= int'(model.max_frame_bytes))
        begin
            for (int i = 0; i < len; i++)
            begin
                b   = 8'($urandom_range(0, 255));
                sum = sum + b;
                frame_q.push_back(b);
            end
            b = 8'($urandom_range(0, 255));
            frame_q.push_back(good_sum ? afd_pkg::SUM_BASE - sum : b);
        end
        n = cut ? $urandom_range(1, frame_q.size() - 1) : frame_q.size();
        spatter = (model.timeout_ticks > 16'd3) && ($urandom_range(0, 2) == 0);
        for (int i = 0; i < n; i++)
        begin
            send_beat(1'b0, frame_q[i]);
            if (spatter && $urandom_range(0, 7) == 0)
                send_ticks($urandom_range(1, 3));
        end
        if (cut && model.timeout_ticks <= 16'd64)
            send_ticks((model.timeout_ticks == 16'd0) ? 1 : int'(model.timeout_ticks));
    endtask

    task automatic random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0)
            tx_burst = !tx_burst;
        if (kind < 13)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 12);
            send_frame(len, $urandom_range(0, 3) != 0, 1'b0);
        end
        else if (kind < 15)
        begin
            len = $urandom_range(int'(model.max_frame_bytes) - 3, 65535);
            send_frame(len, 1'b1, 1'b0);
        end
        else if (kind < 17)
            send_frame($urandom_range(0, 12), 1'b1, 1'b1);
        else if (kind < 19)
        begin
            repeat ($urandom_range(1, 5))
                send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
        else
            settle();
    endtask

    // output side: random stalls, one long hold-off while input keeps coming
    initial
    begin : rx_side
        int               stall_left;
        bit               rx_burst;
        bit               held;
        afd_pkg::result_t got;
        stall_left = 0;
        rx_burst   = 1'b0;
        held       = 1'b0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ready = (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.data_byte         = data_byte;
                got.is_frame_type     = is_frame_type;
                got.end_of_frame      = end_of_frame;
                got.status            = status;
                got.frame_data_length = frame_data_length;
                model.check_result(got);
                if ($urandom_range(0, 63) == 0)
                    rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 15);
                if (!held && model.results_seen == HOLD_AT_RESULT)
                begin
                    held       = 1'b1;
                    stall_left = LONG_HOLD;
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        model      = new();
        beats_sent = 0;
        phases     = 0;
        tx_burst   = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = afd_pkg::REG_TIMEOUT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        req_type   = 1'b0;
        in_byte    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty frames, short frame, length error, idle ticks
        send_frame(0, 1'b1, 1'b0);
        send_frame(0, 1'b0, 1'b0);
        send_frame(3, 1'b1, 1'b0);
        send_beat(1'b0, 8'h7E);
        send_beat(1'b0, 8'hFF);
        send_beat(1'b0, 8'hFF);
        send_ticks(2);
        // leave a frame open across a register change
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'h02);
        set_regs(16'd0, 16'd4);
        send_beat(1'b0, 8'h80);
        send_beat(1'b0, 8'h01);
        send_beat(1'b0, 8'h7E);
        // timeout of zero before the length is known, then too long, then empty
        send_beat(1'b0, 8'h7E);
        send_ticks(1);
        send_frame(1, 1'b1, 1'b0);
        send_frame(0, 1'b1, 1'b0);
        set_regs(16'd1, 16'hFFFF);
        send_beat(1'b0, 8'h7E);
        send_beat(1'b0, 8'h00);
        send_beat(1'b0, 8'h05);
        send_beat(1'b0, 8'hC3);
        send_ticks(1);

        while (beats_sent < TARGET_BEATS)
        begin
            case (phases)
                2: set_regs(16'hFFFF, 16'd4);
                3: set_regs(16'd5, 16'hFFFF);
                default:
                begin
                    case ($urandom_range(0, 5))
                        0: cfg_data = 16'd0;
                        1: cfg_data = 16'd1;
                        2: cfg_data = 16'd3;
                        3: cfg_data = 16'hFFFF;
                        default: cfg_data = 16'($urandom_range(4, 40));
                    endcase
                    case ($urandom_range(0, 3))
                        0: set_regs(cfg_data, 16'd4);
                        1: set_regs(cfg_data, 16'($urandom_range(5, 40)));
                        2: set_regs(cfg_data, 16'($urandom_range(40, 140)));
                        default: set_regs(cfg_data, 16'hFFFF);
                    endcase
                end
            endcase
            repeat (25) random_frame();
        end

        settle();
        repeat (8) @(posedge clk);
        $display("covered %0d beats over %0d register settings, %0d output beats",
                 beats_sent, phases, model.results_seen);
        $display("frames closed: %0d good, %0d bad sum, %0d too long, %0d timed out",
                 model.closed[afd_pkg::ST_OK], model.closed[afd_pkg::ST_BAD_SUM],
                 model.closed[afd_pkg::ST_TOO_LONG], model.closed[afd_pkg::ST_TIMEOUT]);
        if (model.mismatches == 0 && model.pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/afd_pkg.sv
rtl/afd_cfg.sv
rtl/afd_core.sv
rtl/afd_out.sv
rtl/api_frame_deframer.sv
bench/tb.sv
